// ----- sv/gdrs_pkg.sv -----
// Shared types, codes and constants of the grid run scanner.
`timescale 1ns / 1ps

package gdrs_pkg;

  // Default side of the square grid.
  localparam int unsigned GRID_SIDE_DEF = 8;

  // Depth of the command queue between front and back.
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  // Register indexes, taken from paddr[2].
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Register reset values.
  localparam logic [3:0] GRID_WIDTH_RST  = 4'd8;
  localparam logic [3:0] GRID_HEIGHT_RST = 4'd8;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SCAN  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    DIR_H  = 2'd0,
    DIR_V  = 2'd1,
    DIR_DR = 2'd2,
    DIR_DL = 2'd3
  } dir_e;

  // One input item.
  typedef struct packed {
    logic       opcode;
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic [2:0] cell_owner;
    logic [1:0] scan_direction;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0] run_x;
    logic [2:0] run_y;
    logic [3:0] run_length;
    logic [2:0] run_owner;
    logic [1:0] run_direction;
    logic       run_valid;
    logic       last_run;
  } out_item_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic       is_scan;
    logic       in_grid;
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic [2:0] cell_owner;
    dir_e       scan_direction;
  } cmd_t;

  // In-use area, already saturated to the grid side.
  typedef struct packed {
    logic [3:0] used_w;
    logic [3:0] used_h;
  } geom_t;

endpackage

// ----- sv/gdrs_front.sv -----
// Front end: accepts items, classifies them and queues commands for the back end.
`timescale 1ns / 1ps

module gdrs_front #(
  parameter int unsigned GRID_SIDE = gdrs_pkg::GRID_SIDE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gdrs_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output gdrs_pkg::cmd_t    cmd_o
);

  localparam int unsigned QDepth = gdrs_pkg::CMD_QUEUE_DEPTH;
  localparam int unsigned PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  gdrs_pkg::cmd_t    cmd_new;
  gdrs_pkg::cmd_t    q_mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  // Classify the incoming item
  always_comb begin
    cmd_new.is_scan        = (gdrs_pkg::opcode_e'(in_item_i.opcode) == gdrs_pkg::OP_SCAN);
    cmd_new.in_grid        = ({1'b0, in_item_i.cell_x} < 4'(GRID_SIDE)) &&
                             ({1'b0, in_item_i.cell_y} < 4'(GRID_SIDE));
    cmd_new.cell_x         = in_item_i.cell_x;
    cmd_new.cell_y         = in_item_i.cell_y;
    cmd_new.cell_owner     = in_item_i.cell_owner;
    cmd_new.scan_direction = gdrs_pkg::dir_e'(in_item_i.scan_direction);
  end

  assign in_ready_o  = (count_q != CntW'(QDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Store queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- sv/gdrs_back.sv -----
// Back end: grid store, line walker, run tracker and result register.
`timescale 1ns / 1ps

module gdrs_back #(
  parameter int unsigned GRID_SIDE = gdrs_pkg::GRID_SIDE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gdrs_pkg::geom_t    geom_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  gdrs_pkg::cmd_t     cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gdrs_pkg::out_item_t out_item_o
);

  localparam int unsigned Depth = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TAIL,
    ST_CLOSE,
    ST_FLUSH
  } state_e;

  function automatic logic [AddrW-1:0] cell_addr(input logic [2:0] x, input logic [2:0] y);
    logic [6:0] lin;
    lin = 7'(y) * 7'(GRID_SIDE) + 7'(x);
    return lin[AddrW-1:0];
  endfunction

  // Grid store with one valid bit per cell
  logic [2:0]       ram_q [Depth];
  logic [Depth-1:0] cell_v_q;

  state_e           state_q;
  gdrs_pkg::dir_e   dir_q;
  logic             phase_b_q;
  logic             first_q;
  logic [3:0]       li_q, cx_q, cy_q;

  logic             stg_v_q, stg_first_q, stg_last_q;
  logic [2:0]       stg_x_q, stg_y_q, stg_c_q;

  logic [2:0]       own_q, rx_q, ry_q;
  logic [3:0]       len_q;

  logic                pv_q, ov_q;
  gdrs_pkg::out_item_t pend_q, out_q;

  logic             mem_we;
  logic [AddrW-1:0] waddr, raddr;
  logic [3:0]       dx, dy, nx, ny, li_inc, bx;
  logic             next_in, has_next, n_phase_b, scan_last_cell;
  logic [3:0]       nlx, nly, nli;
  logic             issue, consume, new_run, need_close, out_free, can_close, tail_close;
  logic             out_load;
  gdrs_pkg::out_item_t closed_run, marker, pend_last;

  assign mem_we = (state_q == ST_IDLE) && cmd_valid_i && !cmd_i.is_scan && cmd_i.in_grid;
  assign waddr  = cell_addr(cmd_i.cell_x, cmd_i.cell_y);
  assign raddr  = cell_addr(cx_q[2:0], cy_q[2:0]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ram_q[waddr] <= cmd_i.cell_owner;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_v_q <= '0;
    end else if (mem_we) begin
      cell_v_q[waddr] <= 1'b1;
    end
  end

  // Registered read; a cell never written reads as empty
  always_ff @(posedge clk_i) begin
    if (issue) begin
      stg_c_q <= cell_v_q[raddr] ? ram_q[raddr] : 3'd0;
    end
  end

  // Step along the line and pick the next line start
  always_comb begin
    case (dir_q)
      gdrs_pkg::DIR_H:  begin dx = 4'd1;  dy = 4'd0; end
      gdrs_pkg::DIR_V:  begin dx = 4'd0;  dy = 4'd1; end
      gdrs_pkg::DIR_DR: begin dx = 4'd1;  dy = 4'd1; end
      default:          begin dx = 4'hF;  dy = 4'd1; end
    endcase
    nx      = cx_q + dx;
    ny      = cy_q + dy;
    next_in = (nx < geom_i.used_w) && (ny < geom_i.used_h);
    li_inc  = li_q + 4'd1;
    bx      = (dir_q == gdrs_pkg::DIR_DL) ? geom_i.used_w - 4'd1 : 4'd0;

    has_next  = 1'b0;
    nlx       = 4'd0;
    nly       = 4'd0;
    nli       = li_inc;
    n_phase_b = phase_b_q;
    if (!phase_b_q) begin
      if (li_inc < geom_i.used_w) begin
        has_next = 1'b1;
        nlx      = li_inc;
      end else if (dir_q != gdrs_pkg::DIR_V && geom_i.used_h > 4'd1) begin
        has_next  = 1'b1;
        nlx       = bx;
        nly       = 4'd1;
        nli       = 4'd1;
        n_phase_b = 1'b1;
      end
    end else if (li_inc < geom_i.used_h) begin
      has_next = 1'b1;
      nlx      = bx;
      nly      = li_inc;
    end
    scan_last_cell = !next_in && !has_next;
  end

  // Decide whether the staged cell can be taken by the run tracker
  always_comb begin
    new_run    = stg_first_q || (stg_c_q != own_q);
    need_close = new_run && (len_q != 4'd0) && (own_q != 3'd0);
    out_free   = !ov_q || out_ready_i;
    can_close  = !pv_q || out_free;
    consume    = stg_v_q && (!need_close || can_close);
    issue      = (state_q == ST_WALK) && (!stg_v_q || consume);
    tail_close = (len_q != 4'd0) && (own_q != 3'd0);
    out_load   = (consume && need_close && pv_q) ||
                 ((state_q == ST_CLOSE) && tail_close && can_close && pv_q) ||
                 ((state_q == ST_FLUSH) && out_free);

    closed_run = '{run_x: rx_q, run_y: ry_q, run_length: len_q, run_owner: own_q,
                   run_direction: dir_q, run_valid: 1'b1, last_run: 1'b0};
    marker     = '{run_x: 3'd0, run_y: 3'd0, run_length: 4'd0, run_owner: 3'd0,
                   run_direction: dir_q, run_valid: 1'b0, last_run: 1'b1};
    pend_last          = pend_q;
    pend_last.last_run = 1'b1;
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

  // Sequencer, walker, tracker and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= gdrs_pkg::DIR_H;
      phase_b_q   <= 1'b0;
      first_q     <= 1'b0;
      li_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      stg_v_q     <= 1'b0;
      stg_first_q <= 1'b0;
      stg_last_q  <= 1'b0;
      stg_x_q     <= '0;
      stg_y_q     <= '0;
      own_q       <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      len_q       <= '0;
      pv_q        <= 1'b0;
      ov_q        <= 1'b0;
      pend_q      <= '0;
      out_q       <= '0;
    end else begin
      // Load the result register, or drop the result once taken
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end

      // Stage one cell per issue
      if (issue) begin
        stg_v_q     <= 1'b1;
        stg_first_q <= first_q;
        stg_last_q  <= scan_last_cell;
        stg_x_q     <= cx_q[2:0];
        stg_y_q     <= cy_q[2:0];
      end else if (consume) begin
        stg_v_q <= 1'b0;
      end

      // Track runs along the line
      if (consume) begin
        if (need_close) begin
          if (pv_q) begin
            out_q <= pend_q;
          end
          pend_q <= closed_run;
          pv_q   <= 1'b1;
        end
        if (new_run) begin
          rx_q  <= stg_x_q;
          ry_q  <= stg_y_q;
          own_q <= stg_c_q;
          len_q <= 4'd1;
        end else begin
          len_q <= len_q + 4'd1;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && cmd_i.is_scan) begin
            dir_q     <= cmd_i.scan_direction;
            phase_b_q <= (cmd_i.scan_direction == gdrs_pkg::DIR_H);
            first_q   <= 1'b1;
            li_q      <= '0;
            cx_q      <= '0;
            cy_q      <= '0;
            len_q     <= '0;
            own_q     <= '0;
            if (geom_i.used_w == 4'd0 || geom_i.used_h == 4'd0) begin
              state_q <= ST_CLOSE;
            end else begin
              state_q <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (issue) begin
            if (next_in) begin
              cx_q    <= nx;
              cy_q    <= ny;
              first_q <= 1'b0;
            end else if (has_next) begin
              cx_q      <= nlx;
              cy_q      <= nly;
              li_q      <= nli;
              phase_b_q <= n_phase_b;
              first_q   <= 1'b1;
            end else begin
              state_q <= ST_TAIL;
            end
          end
        end
        ST_TAIL: begin
          if (consume && stg_last_q) begin
            state_q <= ST_CLOSE;
          end
        end
        ST_CLOSE: begin
          // Close the run still open at the end of the scan
          if (!tail_close) begin
            state_q <= ST_FLUSH;
          end else if (can_close) begin
            if (pv_q) begin
              out_q <= pend_q;
            end
            pend_q  <= closed_run;
            pv_q    <= 1'b1;
            len_q   <= '0;
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          // Hand out the held run, or the empty marker, with the last flag
          if (out_free) begin
            out_q   <= pv_q ? pend_last : marker;
            pv_q    <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/grid_directional_run_scanner_unit.sv -----
// Flow: a write waits in the command queue and is stored when the idle back end takes it;
//   a closed run is held in one register until the next run closes or the scan ends, and
//   the scan's last result goes from the staging register through ST_CLOSE and ST_FLUSH
//   to the result register, held back while results are stalled. A scan holds the back
//   end while each in-use cell (64 on a full 8 by 8 grid) is read on the one read port.
// Reset: asynchronous, active low; grid reads as empty, size registers return to 8 by 8.
`timescale 1ns / 1ps

module grid_directional_run_scanner_unit #(
  parameter int unsigned GRID_SIDE = gdrs_pkg::GRID_SIDE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gdrs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gdrs_pkg::out_item_t out_item_o
);

  logic [3:0]      width_q, height_q;
  logic            cfg_we;
  gdrs_pkg::geom_t geom;
  logic            cmd_valid, cmd_ready;
  gdrs_pkg::cmd_t  cmd;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // Hold the size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gdrs_pkg::GRID_WIDTH_RST;
      height_q <= gdrs_pkg::GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      case (paddr[2])
        gdrs_pkg::REG_GRID_WIDTH:  width_q  <= pwdata[3:0];
        gdrs_pkg::REG_GRID_HEIGHT: height_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      gdrs_pkg::REG_GRID_WIDTH:  prdata = {28'd0, width_q};
      gdrs_pkg::REG_GRID_HEIGHT: prdata = {28'd0, height_q};
      default:                   prdata = '0;
    endcase
  end

  // Saturate the in-use area to the grid side
  assign geom.used_w = (width_q  > 4'(GRID_SIDE)) ? 4'(GRID_SIDE) : width_q;
  assign geom.used_h = (height_q > 4'(GRID_SIDE)) ? 4'(GRID_SIDE) : height_q;

  gdrs_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  gdrs_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
